// ----- rtl/core/etm_pkg.sv -----
// Shared constants, color matrices and item type for the exposure tone mapper.
// Used by every module of the block except etm_div; depends on nothing.
package etm_pkg;

    localparam int PIX_W             = 16;
    localparam int GAIN_W            = 16;
    localparam int GAIN_RESET        = 256;
    localparam int XYZ_W             = 33;
    localparam int YL_W              = 32;
    localparam int PROD_W            = 32;
    localparam int FRAC_BITS_DEF     = 12;
    localparam int EXP_ADDR_BITS_DEF = 10;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
    localparam int XCOEF_W           = 16;
    localparam int RCOEF_W           = 19;
    localparam int RND_SHIFT         = 24;

    typedef logic        [XCOEF_W-1:0] t_xcoef;
    typedef logic signed [RCOEF_W-1:0] t_rcoef;

    localparam t_xcoef TO_XYZ [3][3] = '{
        '{16'd27027, 16'd23436, 16'd11829},
        '{16'd13933, 16'd46871, 16'd4732},
        '{16'd1265,  16'd7812,  16'd62292}
    };

    localparam t_rcoef TO_RGB [3][3] = '{
        '{19'sd212402, -19'sd100755, -19'sd32676},
        '{-19'sd63517, 19'sd122946,  19'sd2726},
        '{19'sd3644,   -19'sd13369,  19'sd98763}
    };

    typedef struct packed {
        logic             last;
        logic             y_zero;
        logic [XYZ_W-1:0] x;
        logic [XYZ_W-1:0] y;
        logic [XYZ_W-1:0] z;
    } t_xyz_item;

endpackage

// ----- rtl/core/etm_front.sv -----
// Front end: takes RGB pixels and forms CIE XYZ in two stages.
// Depends on etm_pkg.
module etm_front import etm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    input  logic             i_last,
    output logic             o_push,
    output t_xyz_item        o_item,
    output logic [1:0]       o_inflight
);

    logic [PIX_W-1:0]  s_pix [3];
    logic [PROD_W-1:0] r_prod [3][3];
    logic              r_f1_v;
    logic              r_f1_last;
    logic              r_f2_v;
    t_xyz_item         r_f2_item;
    logic [XYZ_W-1:0]  s_sum [3];

    assign s_pix[0] = i_red;
    assign s_pix[1] = i_green;
    assign s_pix[2] = i_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else begin
            r_f1_v <= i_take;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[c][j] <= PROD_W'(TO_XYZ[c][j]) * PROD_W'(s_pix[j]);
            end
        end
        r_f1_last <= i_last;
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s_sum[c] = XYZ_W'(r_prod[c][0]) + XYZ_W'(r_prod[c][1]) + XYZ_W'(r_prod[c][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_f2_item.x      <= s_sum[0];
        r_f2_item.y      <= s_sum[1];
        r_f2_item.z      <= s_sum[2];
        r_f2_item.y_zero <= (s_sum[1] == '0);
        r_f2_item.last   <= r_f1_last;
    end

    assign o_push     = r_f2_v;
    assign o_item     = r_f2_item;
    assign o_inflight = 2'(r_f1_v) + 2'(r_f2_v);

endmodule

// ----- rtl/core/etm_queue.sv -----
// Short item queue between the XYZ front end and the tone-mapping back end.
// Depends on etm_pkg.
module etm_queue import etm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_xyz_item         i_item,
    input  logic              i_pop,
    output t_xyz_item         o_head,
    output logic [QCNT_W-1:0] o_count
);

    t_xyz_item         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

// ----- rtl/core/etm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for chroma rescale.
// Depends on etm_pkg only through the modules that size it.
module etm_div #(
    parameter int DEN_W = 33,
    parameter int QUO_W = 24,
    parameter int NUM_W = 66
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    logic [DEN_W-1:0] s_rem [QUO_W];
    logic [QUO_W-1:0] s_low [QUO_W];
    logic [QUO_W-1:0] s_quo [QUO_W];
    logic [DEN_W-1:0] s_den [QUO_W];
    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_low [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];

    assign s_rem[0] = DEN_W'(i_num >> QUO_W);
    assign s_low[0] = i_num[QUO_W-1:0];
    assign s_quo[0] = '0;
    assign s_den[0] = i_den;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W:0] trial;
        logic           ge;

        if (k > 0) begin : g_link
            assign s_rem[k] = r_rem[k-1];
            assign s_low[k] = r_low[k-1];
            assign s_quo[k] = r_quo[k-1];
            assign s_den[k] = r_den[k-1];
        end

        assign trial = {s_rem[k], s_low[k][QUO_W-1]};
        assign ge    = (trial >= {1'b0, s_den[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? DEN_W'(trial - {1'b0, s_den[k]}) : DEN_W'(trial);
                r_low[k] <= s_low[k] << 1;
                r_quo[k] <= {s_quo[k][QUO_W-2:0], ge};
                r_den[k] <= s_den[k];
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ----- rtl/core/etm_back.sv -----
// Back end: exp table lookup, new luminance, chroma rescale, inverse matrix.
// Depends on etm_pkg and etm_div; fills its exp table after reset.
module etm_back import etm_pkg::*; #(
    parameter int FRAC_BITS           = FRAC_BITS_DEF,
    parameter int EXP_TABLE_ADDR_BITS = EXP_ADDR_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [GAIN_W-1:0]       i_gain,
    input  t_xyz_item               i_item,
    input  logic                    i_have,
    output logic                    o_pop,
    output logic                    o_init_busy,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [PIX_W-1:0] o_red,
    output logic signed [PIX_W-1:0] o_green,
    output logic signed [PIX_W-1:0] o_blue,
    output logic                    o_last
);

    function automatic logic [31:0] exp_step(input int addr_bits);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'd1 << 62;
        term = 64'd1 << 62;
        for (int n = 1; n <= 40; n++) begin
            term = (term >> (addr_bits - 4)) / 64'(n);
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return 32'((sum + (64'd1 << 30)) >> 31);
    endfunction

    localparam int AB        = EXP_TABLE_ADDR_BITS;
    localparam int TBL_LEN   = (1 << AB) + 1;
    localparam int TA_W      = AB + 1;
    localparam int NY_W      = FRAC_BITS + 1;
    localparam int QUO_W     = FRAC_BITS + 12;
    localparam int NUM_W     = XYZ_W + NY_W + 8;
    localparam int POS_SHIFT = FRAC_BITS + 12 - AB;
    localparam int GY_W      = GAIN_W + YL_W;
    localparam int POS_W     = GY_W - POS_SHIFT;
    localparam int SC_W      = QUO_W + 1;
    localparam int P_W       = RCOEF_W + SC_W;
    localparam int A_W       = P_W + 2;
    localparam int NY_SHIFT  = 31 - FRAC_BITS;
    localparam int SB_W      = NY_W + 2;
    localparam logic [32:0] NY_HALF = 33'(1) << (30 - FRAC_BITS);
    localparam logic [32:0] ONE_Q31 = 33'(1) << 31;
    localparam logic [31:0] E31     = exp_step(AB);
    localparam logic signed [A_W-1:0] RND_HALF = A_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [A_W-1:0] SAT_HI   = A_W'(32767);
    localparam logic signed [A_W-1:0] SAT_LO   = -A_W'(32768);

    logic              s_adv;
    logic              r_init_busy;
    logic [TA_W-1:0]   r_init_addr;
    logic [31:0]       r_init_val;
    logic [31:0]       r_tbl [TBL_LEN];

    logic [GY_W-1:0]   s_gy;
    logic              r_s1_v;
    t_xyz_item         r_s1_item;
    logic [POS_W-1:0]  r_s1_pos;

    logic [TA_W-1:0]   s_idx;
    logic              r_s2_v;
    t_xyz_item         r_s2_item;
    logic [15:0]       r_s2_frac;
    logic              r_s2_sat;
    logic [31:0]       r_a;
    logic [31:0]       r_b;

    logic              r_s3_v;
    t_xyz_item         r_s3_item;
    logic [47:0]       r_s3_dp;
    logic [31:0]       r_s3_a;
    logic              r_s3_sat;

    logic [31:0]       s_e;
    logic [32:0]       s_om;
    logic              r_s4_v;
    t_xyz_item         r_s4_item;
    logic [NY_W-1:0]   r_s4_ny;

    logic                   r_s5_v;
    logic [XYZ_W+NY_W-1:0]  r_s5_px;
    logic [XYZ_W+NY_W-1:0]  r_s5_pz;
    logic [XYZ_W-1:0]       r_s5_y;
    logic [NY_W-1:0]        r_s5_ny;
    logic                   r_s5_last;
    logic                   r_s5_zero;

    logic [NUM_W-1:0]  s_num_x;
    logic [NUM_W-1:0]  s_num_z;
    logic [QUO_W-1:0]  s_qx;
    logic [QUO_W-1:0]  s_qz;
    logic [QUO_W-1:0]  r_dl_v;
    logic [SB_W-1:0]   r_dl_pay [QUO_W];
    logic [SB_W-1:0]   s_dl_out;

    logic signed [SC_W-1:0] s_sc [3];
    logic                   r_m1_v;
    logic signed [P_W-1:0]  r_m1_p [3][3];
    logic                   r_m1_last;
    logic                   r_m1_zero;

    logic signed [A_W-1:0]   s_acc [3];
    logic signed [A_W-1:0]   s_shr [3];
    logic signed [PIX_W-1:0] s_rgb [3];
    logic                    r_o_v;
    logic signed [PIX_W-1:0] r_o_rgb [3];
    logic                    r_o_last;

    assign s_adv = !r_o_v || i_ready;
    assign o_pop = s_adv && i_have && !r_init_busy;

    // table fill sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_busy <= 1'b1;
            r_init_addr <= '0;
            r_init_val  <= 32'(ONE_Q31);
        end else if (r_init_busy) begin
            r_init_val  <= 32'((64'(r_init_val) * 64'(E31) + (64'd1 << 30)) >> 31);
            r_init_addr <= r_init_addr + TA_W'(1);
            if (r_init_addr == TA_W'(TBL_LEN - 1)) begin
                r_init_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_init_busy) begin
            r_tbl[r_init_addr] <= r_init_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_dl_v <= '0;
            r_m1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (s_adv) begin
            r_s1_v <= o_pop;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_dl_v <= {r_dl_v[QUO_W-2:0], r_s5_v};
            r_m1_v <= r_dl_v[QUO_W-1];
            r_o_v  <= r_m1_v;
        end
    end

    assign s_gy = GY_W'(i_gain) * GY_W'(i_item.y[YL_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_s1_item <= i_item;
            r_s1_pos  <= s_gy[GY_W-1:POS_SHIFT];
        end
    end

    assign s_idx = {1'b0, r_s1_pos[16+AB-1:16]};

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_s2_item <= r_s1_item;
            r_s2_frac <= r_s1_pos[15:0];
            r_s2_sat  <= |r_s1_pos[POS_W-1:16+AB];
            r_a       <= r_tbl[s_idx];
            r_b       <= r_tbl[s_idx + TA_W'(1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_s3_item <= r_s2_item;
            r_s3_dp   <= 48'(r_a - r_b) * 48'(r_s2_frac);
            r_s3_a    <= r_a;
            r_s3_sat  <= r_s2_sat;
        end
    end

    assign s_e  = r_s3_sat ? 32'd0 : r_s3_a - 32'(r_s3_dp >> 16);
    assign s_om = ONE_Q31 - 33'(s_e) + NY_HALF;

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_s4_item <= r_s3_item;
            r_s4_ny   <= NY_W'(s_om >> NY_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_s5_px   <= (XYZ_W+NY_W)'(r_s4_item.x) * (XYZ_W+NY_W)'(r_s4_ny);
            r_s5_pz   <= (XYZ_W+NY_W)'(r_s4_item.z) * (XYZ_W+NY_W)'(r_s4_ny);
            r_s5_y    <= r_s4_item.y;
            r_s5_ny   <= r_s4_ny;
            r_s5_last <= r_s4_item.last;
            r_s5_zero <= r_s4_item.y_zero;
        end
    end

    assign s_num_x = {r_s5_px, 8'd0} + NUM_W'(r_s5_y >> 1);
    assign s_num_z = {r_s5_pz, 8'd0} + NUM_W'(r_s5_y >> 1);

    etm_div #(
        .DEN_W (XYZ_W),
        .QUO_W (QUO_W),
        .NUM_W (NUM_W)
    ) u_div_x (
        .i_clk (i_clk),
        .i_en  (s_adv),
        .i_num (s_num_x),
        .i_den (r_s5_y),
        .o_quo (s_qx)
    );

    etm_div #(
        .DEN_W (XYZ_W),
        .QUO_W (QUO_W),
        .NUM_W (NUM_W)
    ) u_div_z (
        .i_clk (i_clk),
        .i_en  (s_adv),
        .i_num (s_num_z),
        .i_den (r_s5_y),
        .o_quo (s_qz)
    );

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_dl_pay[0] <= {r_s5_last, r_s5_zero, r_s5_ny};
            for (int k = 1; k < QUO_W; k++) begin
                r_dl_pay[k] <= r_dl_pay[k-1];
            end
        end
    end

    assign s_dl_out = r_dl_pay[QUO_W-1];
    assign s_sc[0]  = {1'b0, s_qx};
    assign s_sc[1]  = SC_W'({s_dl_out[NY_W-1:0], 8'd0});
    assign s_sc[2]  = {1'b0, s_qz};

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            for (int c = 0; c < 3; c++) begin
                for (int j = 0; j < 3; j++) begin
                    r_m1_p[c][j] <= P_W'(TO_RGB[c][j]) * P_W'(s_sc[j]);
                end
            end
            r_m1_last <= s_dl_out[SB_W-1];
            r_m1_zero <= s_dl_out[SB_W-2];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s_acc[c] = A_W'(r_m1_p[c][0]) + A_W'(r_m1_p[c][1]) + A_W'(r_m1_p[c][2])
                     + RND_HALF;
            s_shr[c] = s_acc[c] >>> RND_SHIFT;
            if (s_shr[c] > SAT_HI) begin
                s_rgb[c] = PIX_W'(SAT_HI);
            end else if (s_shr[c] < SAT_LO) begin
                s_rgb[c] = PIX_W'(SAT_LO);
            end else begin
                s_rgb[c] = PIX_W'(s_shr[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            for (int c = 0; c < 3; c++) begin
                r_o_rgb[c] <= r_m1_zero ? '0 : s_rgb[c];
            end
            r_o_last <= r_m1_last;
        end
    end

    assign o_init_busy = r_init_busy;
    assign o_valid     = r_o_v;
    assign o_red       = r_o_rgb[0];
    assign o_green     = r_o_rgb[1];
    assign o_blue      = r_o_rgb[2];
    assign o_last      = r_o_last;

endmodule

// ----- rtl/core/exposure_tone_map_pixel.sv -----
// Exposure tone mapper top level: config register, XYZ front end, queue, back end.
// Depends on etm_pkg, etm_front, etm_queue and etm_back.
//
// Takes one linear RGB pixel (unsigned Q4.12) per clock and returns one signed,
// saturated RGB pixel per clock with the luminance mapped to 1-exp(-k*Y) and the
// chromaticity kept, while the output is not stalled and the queue has room.
// Throughput is then one pixel per cycle; the latency from input accept to output
// valid is set mostly by the two pipelined dividers that retire one quotient bit
// per stage. After reset the exp table is filled one entry per cycle, so no pixel
// is taken until all 2^EXP_TABLE_ADDR_BITS + 1 entries are written; the exposure
// register can be written at any time the block is idle.
module exposure_tone_map_pixel import etm_pkg::*; #(
    parameter int FRAC_BITS           = FRAC_BITS_DEF,
    parameter int EXP_TABLE_ADDR_BITS = EXP_ADDR_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [GAIN_W-1:0]       i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [PIX_W-1:0]        i_red_in,
    input  logic [PIX_W-1:0]        i_green_in,
    input  logic [PIX_W-1:0]        i_blue_in,
    input  logic                    i_last_pixel,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [PIX_W-1:0] o_red_out,
    output logic signed [PIX_W-1:0] o_green_out,
    output logic signed [PIX_W-1:0] o_blue_out,
    output logic                    o_last_pixel_out
);

    logic [GAIN_W-1:0] r_gain;
    logic              s_take;
    logic              s_push;
    t_xyz_item         s_item;
    logic [1:0]        s_inflight;
    logic              s_pop;
    t_xyz_item         s_head;
    logic [QCNT_W-1:0] s_count;
    logic [QCNT_W:0]   s_occ;
    logic              s_init_busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_W'(GAIN_RESET);
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    assign s_occ   = (QCNT_W+1)'(s_count) + (QCNT_W+1)'(s_inflight);
    assign o_ready = !s_init_busy && (s_occ < (QCNT_W+1)'(QUEUE_DEPTH));
    assign s_take  = i_valid && o_ready;

    etm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (s_take),
        .i_red      (i_red_in),
        .i_green    (i_green_in),
        .i_blue     (i_blue_in),
        .i_last     (i_last_pixel),
        .o_push     (s_push),
        .o_item     (s_item),
        .o_inflight (s_inflight)
    );

    etm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_item  (s_item),
        .i_pop   (s_pop),
        .o_head  (s_head),
        .o_count (s_count)
    );

    etm_back #(
        .FRAC_BITS           (FRAC_BITS),
        .EXP_TABLE_ADDR_BITS (EXP_TABLE_ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain      (r_gain),
        .i_item      (s_head),
        .i_have      (s_count != '0),
        .o_pop       (s_pop),
        .o_init_busy (s_init_busy),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red       (o_red_out),
        .o_green     (o_green_out),
        .o_blue      (o_blue_out),
        .o_last      (o_last_pixel_out)
    );

endmodule
